[design/sle_pkg.sv]
// Package for the sorted list engine: codes, widths and shared structs.
`default_nettype none
package sle_pkg;

  localparam int SLE_CAPACITY = 16;
  localparam int KEY_W        = 32;
  localparam int POS_W        = 4;
  localparam int OUT_CNT_W    = 5;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } sle_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_RANGE   = 2'd3
  } sle_status_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic             ins;   // insert, already gated by not full
    logic             rem;   // remove, already gated by key found
    logic [KEY_W-1:0] key;
  } sle_ctl_t;

  // compare flags a cell hands back
  typedef struct packed {
    logic gt;  // occupied and key held > key presented (signed)
    logic ge;  // occupied and key held >= key presented (signed)
    logic eq;  // occupied and key held equals key presented
  } sle_flags_t;

endpackage : sle_pkg
`default_nettype wire

[design/sorted_list_engine.sv]
// Top level of the sorted list engine: cell chain, count and result register.
//
// Sorted list engine. Holds up to CAPACITY signed 32-bit keys in ascending
// order in a row of cells, one key per cell. An insert puts its key after
// any equal keys; a remove deletes the lowest-index equal key and closes the
// gap; a read returns the key at in_position (0 is the smallest). A
// transaction is taken at a rising edge with start high and busy low. Every
// cell compares its key against the broadcast key and shifts toward its
// neighbor in the same cycle, so one transaction is taken every clock
// cycle and busy never rises. The result appears on the out_ ports in the
// cycle after acceptance, for exactly one cycle, with out_valid high; the
// receiver cannot stall it, so it must capture each result when it shows.
// Status: ok, list full (insert refused), key not found, position out of
// range (read_value is zero). out_entry_count is the count after the
// operation, taken to 5 bits. Kind code 3 does nothing and reports ok.
// Cells beyond the count hold stale keys that are never reported.
`default_nettype none
module sorted_list_engine
  import sle_pkg::*;
#(
  parameter int CAPACITY = SLE_CAPACITY
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_kind,
  input  wire logic [KEY_W-1:0]  in_key_value,
  input  wire logic [POS_W-1:0]  in_position,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [KEY_W-1:0]       out_read_value,
  output logic [OUT_CNT_W-1:0]   out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  // only the first positions can be addressed by a read
  localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  sle_status_t       status_r, status_nxt;
  logic [KEY_W-1:0]  value_r, value_nxt;
  logic [CNT_W-1:0]  ocount_r;

  logic              accept;
  logic              full;
  logic              found;
  sle_ctl_t          ctl;

  logic [KEY_W-1:0]  keys   [CAPACITY];
  sle_flags_t        flags  [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = count_r >= CNT_W'(CAPACITY);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      eq_vec[i] = flags[i].eq;
    end
  end
  assign found = |eq_vec;

  assign ctl.key = in_key_value;
  assign ctl.ins = accept && (in_kind == KIND_INSERT) && !full;
  assign ctl.rem = accept && (in_kind == KIND_REMOVE) && found;

  // cell chain: left neighbor feeds inserts, right neighbor feeds removes
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_W-1:0] lkey, rkey;
    logic             lgt;
    if (g == 0) begin : g_first
      assign lkey = '0;
      assign lgt  = 1'b0;
    end else begin : g_mid
      assign lkey = keys[g-1];
      assign lgt  = flags[g-1].gt;
    end
    if (g == CAPACITY - 1) begin : g_last
      assign rkey = keys[g];
    end else begin : g_notlast
      assign rkey = keys[g+1];
    end
    sle_cell #(
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .left_key  (lkey),
      .left_gt   (lgt),
      .right_key (rkey),
      .flags     (flags[g]),
      .key_out   (keys[g])
    );
  end

  // status, read data and next count
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_OK;
    value_nxt  = '0;
    case (sle_kind_t'(in_kind))
      KIND_INSERT: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + CNT_W'(1);
      end
      KIND_REMOVE: begin
        if (found) count_nxt  = count_r - CNT_W'(1);
        else       status_nxt = ST_MISSING;
      end
      KIND_READ: begin
        status_nxt = ST_RANGE;
        for (int i = 0; i < RD_N; i++) begin
          if ((in_position == POS_W'(i)) && (CNT_W'(i) < count_r)) begin
            status_nxt = ST_OK;
            value_nxt  = keys[i];
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      ocount_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_read_value  = value_r;
  assign out_entry_count = OUT_CNT_W'(ocount_r);

endmodule : sorted_list_engine
`default_nettype wire

[design/sle_cell.sv]
// One cell of the sorted key chain: holds one key, compares and shifts.
`default_nettype none
module sle_cell
  import sle_pkg::*;
#(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire sle_ctl_t         ctl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [KEY_W-1:0] left_key,
  input  wire logic             left_gt,
  input  wire logic [KEY_W-1:0] right_key,
  output sle_flags_t            flags,
  output logic [KEY_W-1:0]      key_out
);

  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] key_nxt;
  logic             occ;
  logic             at_end;

  assign occ    = CNT_W'(IDX) < count;
  assign at_end = CNT_W'(IDX) == count;

  assign flags.gt = occ && ($signed(key_r) >  $signed(ctl.key));
  assign flags.ge = occ && ($signed(key_r) >= $signed(ctl.key));
  assign flags.eq = occ && (key_r == ctl.key);

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins) begin
      if (left_gt) begin
        key_nxt = left_key;          // make room: move up one place
      end else if (flags.gt || at_end) begin
        key_nxt = ctl.key;           // insertion point
      end
    end else if (ctl.rem && flags.ge) begin
      key_nxt = right_key;           // close the gap
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_out = key_r;

endmodule : sle_cell
`default_nettype wire

[design/sle_checker.sv]
// Port-level assertions for the sorted list engine, bound to the top level.
`default_nettype none
module sle_checker
  import sle_pkg::*;
#(
  parameter int CAPACITY = SLE_CAPACITY
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic [1:0]           out_status,
  input wire logic [KEY_W-1:0]     out_read_value,
  input wire logic [OUT_CNT_W-1:0] out_entry_count
);

  // every accepted transaction gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> out_valid)
    else $error("accepted transaction produced no result");

  // no result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |=> !out_valid)
    else $error("result without accepted transaction");

  // a refused insert only happens with the list at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |->
      (out_entry_count == OUT_CNT_W'(CAPACITY)))
    else $error("full status with count below capacity");

  // out-of-range read returns zero data
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_RANGE)) |-> (out_read_value == '0))
    else $error("out-of-range read returned data");

endmodule : sle_checker

bind sorted_list_engine sle_checker #(
  .CAPACITY (CAPACITY)
) u_sle_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_read_value  (out_read_value),
  .out_entry_count (out_entry_count)
);
`default_nettype wire
